@@ rtl/mscc_pkg.sv @@
// Shared constants and codes for the motion sensor curve mapper.
package mscc_pkg;

   // Default sizing of the mapper
   localparam int SAMPLE_BITS_DEF   = 16;
   localparam int LOG_ENTRIES_DEF   = 1024;
   localparam int FRACTION_BITS_DEF = 16;

   // Channel payload widths
   localparam int OP_BITS        = 2;
   localparam int CC_BITS        = 7;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 8;

   // Operation codes of a request
   localparam logic [OP_BITS-1:0] OP_SAMPLE  = 2'd0;
   localparam logic [OP_BITS-1:0] OP_CAPTURE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_CLEAR   = 2'd2;

   // Register indexes of the CSR channel
   localparam logic [CSR_INDEX_BITS-1:0] REG_ACCEL_MODE  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CURVE_SHAPE = 1'd1;

   // Curve codes; unlisted codes map linearly
   localparam logic [2:0] CURVE_LINEAR     = 3'd0;
   localparam logic [2:0] CURVE_LOG        = 3'd1;
   localparam logic [2:0] CURVE_SQUARE     = 3'd2;
   localparam logic [2:0] CURVE_LOG_SQUARE = 3'd3;
   localparam logic [2:0] CURVE_SQUARE_LOG = 3'd4;

   // Log generator: (e-1) in Q32 without its integer one, ln2 in Q32, 1.0 in Q30
   localparam logic [31:0] E_MINUS_ONE_FRAC = 32'hB7E1_5163;
   localparam logic [31:0] LN_TWO_Q32       = 32'hB172_17F8;
   localparam logic [31:0] LOG_ONE_Q30      = 32'h4000_0000;
   localparam int          LOG_STEPS        = 30;

   // Output scaling
   localparam logic [CC_BITS-1:0] SCALE_FULL    = 7'd127;
   localparam logic [CC_BITS-1:0] SCALE_HALF_LO = 7'd64;
   localparam logic [CC_BITS-1:0] SCALE_HALF_HI = 7'd63;
   localparam logic [CC_BITS:0]   CC_CENTRE     = 8'd64;
   localparam logic [CC_BITS-1:0] CC_MAX        = 7'd127;

endpackage

@@ rtl/mscc_if.sv @@
// Valid/ready channel interfaces of the motion sensor curve mapper.
interface mscc_req_if #(
   parameter int SAMPLE_BITS = mscc_pkg::SAMPLE_BITS_DEF
);
   logic                                 valid;
   logic                                 ready;
   logic [mscc_pkg::OP_BITS-1:0]         operation;
   logic signed [SAMPLE_BITS-1:0]        sample;

   modport source (output valid, output operation, output sample, input ready);
   modport sink   (input valid, input operation, input sample, output ready);
endinterface

interface mscc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [mscc_pkg::CC_BITS-1:0]         cc_value;

   modport source (output valid, output cc_value, input ready);
   modport sink   (input valid, input cc_value, output ready);
endinterface

interface mscc_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [mscc_pkg::CSR_INDEX_BITS-1:0]  index;
   logic [mscc_pkg::CSR_DATA_BITS-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/mscc_recentre.sv @@
// Iterative restoring divider that re-centres an accelerometer sample on its zero offset.
module mscc_recentre #(
   parameter int SAMPLE_BITS = mscc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic signed [SAMPLE_BITS-2:0] offset,
   output logic                          done,
   output logic signed [SAMPLE_BITS-1:0] result
);

   localparam int SB       = SAMPLE_BITS;
   localparam int WB       = SB + 1;
   localparam int DEN_BITS = SB - 2;
   localparam int CNT_BITS = $clog2(SB + 1);
   localparam int ONE_G    = 1 << (SB - 3);
   localparam logic signed [WB-1:0] G_EXT = WB'(ONE_G);

   // Clamp a quotient to the sample range and apply the sign
   function automatic logic signed [SB-1:0] saturate(input logic pos, input logic [SB-1:0] q);
      logic [SB-1:0] mag;
      if (pos) begin
         mag = q[SB-1] ? {1'b0, {(SB-1){1'b1}}} : q;
      end else begin
         mag = (q[SB-1] && (|q[SB-2:0])) ? {1'b1, {(SB-1){1'b0}}} : q;
      end
      return pos ? $signed(mag) : $signed(-mag);
   endfunction

   logic signed [WB-1:0] s_ext, o_ext, diff, den_full;
   logic                 ge, ovf;
   logic [SB-1:0]        mag;
   logic [DEN_BITS-1:0]  den;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 ge_ff, ge_in;
   logic [DEN_BITS-1:0]  den_ff, den_in;
   logic [DEN_BITS-1:0]  rem_ff, rem_in;
   logic [SB-1:0]        nbits_ff, nbits_in;
   logic [SB-1:0]        q_ff, q_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic signed [SB-1:0] result_ff, result_in;

   logic [DEN_BITS:0]    rem_sh, rem_sub;
   logic                 fits;
   logic [SB-1:0]        q_step;

   // Split into magnitude and divisor by the side of the offset
   always_comb begin
      s_ext    = {sample[SB-1], sample};
      o_ext    = {{2{offset[SB-2]}}, offset};
      ge       = (s_ext >= o_ext);
      diff     = ge ? (s_ext - o_ext) : (o_ext - s_ext);
      mag      = diff[SB-1:0];
      den_full = ge ? (G_EXT - o_ext) : (G_EXT + o_ext);
      den      = den_full[DEN_BITS-1:0];
      // quotient reaches 2^SB exactly when mag >= 8 * den
      ovf      = ({1'b0, mag} >= {den, 3'b000});
   end

   // One quotient bit per cycle
   always_comb begin
      rem_sh  = {rem_ff, nbits_ff[SB-1]};
      fits    = (rem_sh >= {1'b0, den_ff});
      rem_sub = rem_sh - {1'b0, den_ff};
      q_step  = {q_ff[SB-2:0], fits};

      busy_in   = busy_ff;
      done_in   = 1'b0;
      ge_in     = ge_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      nbits_in  = nbits_ff;
      q_in      = q_ff;
      cnt_in    = cnt_ff;
      result_in = result_ff;

      if (start) begin
         ge_in  = ge;
         den_in = den;
         if (ovf) begin
            result_in = saturate(ge, '1);
            done_in   = 1'b1;
         end else begin
            busy_in  = 1'b1;
            rem_in   = DEN_BITS'(mag[SB-1:3]);
            nbits_in = {mag[2:0], {(SB-3){1'b0}}};
            q_in     = '0;
            cnt_in   = CNT_BITS'(SB);
         end
      end else if (busy_ff) begin
         rem_in   = fits ? rem_sub[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];
         nbits_in = nbits_ff << 1;
         q_in     = q_step;
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in   = 1'b0;
            done_in   = 1'b1;
            result_in = saturate(ge_ff, q_step);
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      ge_ff     <= ge_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      nbits_ff  <= nbits_in;
      q_ff      <= q_in;
      cnt_ff    <= cnt_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

@@ rtl/motion_sensor_curve_to_cc_core.sv @@
// Motion sensor curve mapper top level: sequencer around one shared 32x32 multiplier.
// Sample path: shape step then final scaling for linear and square curves; log curves
// add a seed step, 30 squaring steps of the shared multiplier and an ln2 step, and in
// accelerometer mode the re-centring divider runs first (it may saturate early).
// Requests are taken only while idle, one sample at a time; capture and clear stay idle.
// Synchronous active-high reset clears config, last reading, zero offset and handshakes.
module motion_sensor_curve_to_cc_core #(
   parameter int SAMPLE_BITS       = mscc_pkg::SAMPLE_BITS_DEF,
   parameter int LOG_TABLE_ENTRIES = mscc_pkg::LOG_ENTRIES_DEF,
   parameter int FRACTION_BITS     = mscc_pkg::FRACTION_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   mscc_req_if.sink    req_bus,
   mscc_rsp_if.source  rsp_bus,
   mscc_csr_if.sink    csr_bus
);

   localparam int SB      = SAMPLE_BITS;
   localparam int FB      = FRACTION_BITS;
   // table size must be a power of two; the block does not check it
   localparam int LOGN    = $clog2(LOG_TABLE_ENTRIES);
   localparam int ONE_G   = 1 << (SB - 3);
   localparam int LCNT_W  = $clog2(mscc_pkg::LOG_STEPS);
   localparam int CCB     = mscc_pkg::CC_BITS;
   localparam int SH_LIN_N   = SB;
   localparam int SH_SQ_N    = 2 * SB;
   localparam int SH_SPLIT_N = 2 * SB - 2;
   localparam logic signed [SB-1:0] OFS_MAX = SB'(ONE_G - 1);
   localparam logic signed [SB-1:0] OFS_MIN = SB'(1 - ONE_G);
   localparam logic [63:0]          LOG_RND = 64'd1 << (61 - FB);

   // Sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIV   = 3'd1;
   localparam logic [2:0] S_SHAPE = 3'd2;
   localparam logic [2:0] S_LOGX  = 3'd3;
   localparam logic [2:0] S_LOGSQ = 3'd4;
   localparam logic [2:0] S_LOGLN = 3'd5;
   localparam logic [2:0] S_MUL2  = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   // Final shift selection
   localparam logic [1:0] SH_LIN   = 2'd0;
   localparam logic [1:0] SH_SQ    = 2'd1;
   localparam logic [1:0] SH_SPLIT = 2'd2;
   localparam logic [1:0] SH_LOG   = 2'd3;

   logic                      accel_mode_ff, accel_mode_in;
   logic [2:0]                curve_shape_ff, curve_shape_in;
   logic signed [SB-1:0]      last_reading_ff, last_reading_in;
   logic signed [SB-2:0]      zero_offset_ff, zero_offset_in;
   logic [2:0]                state_ff, state_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CCB-1:0]            rsp_cc_ff, rsp_cc_in;

   logic signed [SB-1:0]      v_ff, v_in;
   logic [31:0]               t_ff, t_in;
   logic [31:0]               opb_ff, opb_in;
   logic [LOGN-1:0]           idx_ff, idx_in;
   logic [30:0]               x_ff, x_in;
   logic [30:0]               lg_ff, lg_in;
   logic [LCNT_W-1:0]         cnt_ff, cnt_in;
   logic [1:0]                sh_ff, sh_in;
   logic                      base_ff, base_in;
   logic [CCB-1:0]            cc_ff, cc_in;

   logic                      req_fire, out_free, div_start, div_done;
   logic signed [SB-1:0]      sample_in, div_result, ofs_sel;
   logic [SB-1:0]             w, h;
   logic                      neg;
   logic [SB+LOGN-1:0]        w_wide, h_wide, idx_full_w, idx_half_w, idx_half_h;

   logic                      shape_log, shape_mul, shape_base;
   logic [SB-1:0]             shape_a, shape_b2;
   logic [CCB-1:0]            shape_k;
   logic [1:0]                shape_sh;
   logic [LOGN-1:0]           shape_idx;

   logic [31:0]               mul_a, mul_b;
   logic [63:0]               prod, ei, rnd, shifted;
   logic [31:0]               x0, y;
   logic                      mul_over;
   logic [CCB:0]              mul_sum;
   logic [CCB-1:0]            mul_cc;

   assign sample_in = req_bus.sample;
   assign req_fire  = req_bus.valid && req_bus.ready;
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign div_start = req_fire && (req_bus.operation == mscc_pkg::OP_SAMPLE) && accel_mode_ff;

   // Offset re-centring divider
   mscc_recentre #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_recentre (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .sample (sample_in),
      .offset (zero_offset_ff),
      .done   (div_done),
      .result (div_result)
   );

   // Curve-domain views of the value: offset binary and magnitude
   always_comb begin
      w          = {~v_ff[SB-1], v_ff[SB-2:0]};
      h          = v_ff;
      neg        = v_ff[SB-1];
      w_wide     = {w, {LOGN{1'b0}}};
      h_wide     = {h, {LOGN{1'b0}}};
      idx_full_w = w_wide >> SB;
      idx_half_w = w_wide >> (SB - 1);
      idx_half_h = h_wide >> (SB - 1);
   end

   // Decode curve path for the current value
   always_comb begin
      shape_log  = 1'b0;
      shape_mul  = 1'b0;
      shape_base = 1'b0;
      shape_a    = w;
      shape_b2   = w;
      shape_k    = mscc_pkg::SCALE_FULL;
      shape_sh   = SH_LIN;
      shape_idx  = idx_full_w[LOGN-1:0];
      unique case (curve_shape_ff)
         mscc_pkg::CURVE_LOG: begin
            shape_log = 1'b1;
         end
         mscc_pkg::CURVE_SQUARE: begin
            shape_mul = 1'b1;
            shape_sh  = SH_SQ;
         end
         mscc_pkg::CURVE_LOG_SQUARE: begin
            if (neg) begin
               shape_log = 1'b1;
               shape_k   = mscc_pkg::SCALE_HALF_LO;
               shape_idx = idx_half_w[LOGN-1:0];
            end else begin
               shape_mul  = 1'b1;
               shape_a    = h;
               shape_b2   = h;
               shape_k    = mscc_pkg::SCALE_HALF_HI;
               shape_sh   = SH_SPLIT;
               shape_base = 1'b1;
            end
         end
         mscc_pkg::CURVE_SQUARE_LOG: begin
            if (neg) begin
               shape_mul = 1'b1;
               shape_k   = mscc_pkg::SCALE_HALF_LO;
               shape_sh  = SH_SPLIT;
            end else begin
               shape_log  = 1'b1;
               shape_k    = mscc_pkg::SCALE_HALF_HI;
               shape_idx  = idx_half_h[LOGN-1:0];
               shape_base = 1'b1;
            end
         end
         default: begin
            // linear, also for unused codes
         end
      endcase
      if (shape_log) begin
         shape_sh = SH_LOG;
      end
   end

   // Shared multiplier operand select
   always_comb begin
      mul_a = t_ff;
      mul_b = opb_ff;
      unique case (state_ff)
         S_SHAPE: begin
            mul_a = 32'(shape_a);
            mul_b = 32'(shape_k);
         end
         S_LOGX: begin
            mul_a = mscc_pkg::E_MINUS_ONE_FRAC;
            mul_b = 32'(idx_ff);
         end
         S_LOGSQ: begin
            mul_a = 32'(x_ff);
            mul_b = 32'(x_ff);
         end
         S_LOGLN: begin
            mul_a = 32'(lg_ff);
            mul_b = mscc_pkg::LN_TWO_Q32;
         end
         default: begin
            // final scaling product
         end
      endcase
   end

   assign prod = {32'h0, mul_a} * {32'h0, mul_b};

   // Log seed, squaring step and rounding around the shared product
   always_comb begin
      ei  = prod + {{(32 - LOGN){1'b0}}, idx_ff, 32'h0};
      x0  = 32'(ei >> (LOGN + 2)) + mscc_pkg::LOG_ONE_Q30;
      y   = prod[61:30];
      rnd = prod + LOG_RND;
   end

   // Final shift, centre offset and clamp
   always_comb begin
      unique case (sh_ff)
         SH_LIN:   shifted = prod >> SH_LIN_N;
         SH_SQ:    shifted = prod >> SH_SQ_N;
         SH_SPLIT: shifted = prod >> SH_SPLIT_N;
         default:  shifted = prod >> FB;
      endcase
      mul_over = |shifted[63:CCB];
      mul_sum  = {1'b0, shifted[CCB-1:0]} + (base_ff ? mscc_pkg::CC_CENTRE : '0);
      mul_cc   = (mul_over || mul_sum[CCB]) ? mscc_pkg::CC_MAX : mul_sum[CCB-1:0];
   end

   // Clamp last reading into the offset range
   always_comb begin
      priority if (last_reading_ff > OFS_MAX) begin
         ofs_sel = OFS_MAX;
      end else if (last_reading_ff < OFS_MIN) begin
         ofs_sel = OFS_MIN;
      end else begin
         ofs_sel = last_reading_ff;
      end
   end

   // Sequencer and register updates
   always_comb begin
      accel_mode_in   = accel_mode_ff;
      curve_shape_in  = curve_shape_ff;
      last_reading_in = last_reading_ff;
      zero_offset_in  = zero_offset_ff;
      state_in        = state_ff;
      v_in            = v_ff;
      t_in            = t_ff;
      opb_in          = opb_ff;
      idx_in          = idx_ff;
      x_in            = x_ff;
      lg_in           = lg_ff;
      cnt_in          = cnt_ff;
      sh_in           = sh_ff;
      base_in         = base_ff;
      cc_in           = cc_ff;

      // take register writes on any cycle
      if (csr_bus.valid && csr_bus.ready) begin
         if (csr_bus.index == mscc_pkg::REG_ACCEL_MODE) begin
            accel_mode_in = csr_bus.data[0];
         end else if (csr_bus.index == mscc_pkg::REG_CURVE_SHAPE) begin
            curve_shape_in = csr_bus.data[2:0];
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_bus.operation)
                  mscc_pkg::OP_SAMPLE: begin
                     last_reading_in = sample_in;
                     v_in            = sample_in;
                     state_in        = accel_mode_ff ? S_DIV : S_SHAPE;
                  end
                  mscc_pkg::OP_CAPTURE: begin
                     if (accel_mode_ff) begin
                        zero_offset_in = (SB - 1)'(ofs_sel);
                     end
                  end
                  mscc_pkg::OP_CLEAR: begin
                     zero_offset_in = '0;
                  end
                  default: begin
                     // unused code: drop
                  end
               endcase
            end
         end
         S_DIV: begin
            if (div_done) begin
               v_in     = div_result;
               state_in = S_SHAPE;
            end
         end
         S_SHAPE: begin
            sh_in   = shape_sh;
            base_in = shape_base;
            if (shape_log) begin
               idx_in   = shape_idx;
               opb_in   = 32'(shape_k);
               state_in = S_LOGX;
            end else if (shape_mul) begin
               t_in     = prod[31:0];
               opb_in   = 32'(shape_b2);
               state_in = S_MUL2;
            end else begin
               t_in     = 32'(w);
               opb_in   = 32'(mscc_pkg::SCALE_FULL);
               state_in = S_MUL2;
            end
         end
         S_LOGX: begin
            if (x0[31]) begin
               x_in  = x0[31:1];
               lg_in = 31'd1;
            end else begin
               x_in  = x0[30:0];
               lg_in = 31'd0;
            end
            cnt_in   = LCNT_W'(mscc_pkg::LOG_STEPS - 1);
            state_in = S_LOGSQ;
         end
         S_LOGSQ: begin
            // square, renormalize, shift in one log2 bit
            if (y[31]) begin
               x_in  = y[31:1];
               lg_in = {lg_ff[29:0], 1'b1};
            end else begin
               x_in  = y[30:0];
               lg_in = {lg_ff[29:0], 1'b0};
            end
            if (cnt_ff == '0) begin
               state_in = S_LOGLN;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_LOGLN: begin
            t_in     = 32'(rnd >> (62 - FB));
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cc_in    = mul_cc;
            state_in = S_DONE;
         end
         default: begin
            // hold the result until the output register frees up
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_cc_in    = rsp_cc_ff;
      if (state_ff == S_DONE && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_cc_in    = cc_ff;
      end
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         accel_mode_ff   <= 1'b0;
         curve_shape_ff  <= mscc_pkg::CURVE_LINEAR;
         last_reading_ff <= '0;
         zero_offset_ff  <= '0;
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
      end else begin
         accel_mode_ff   <= accel_mode_in;
         curve_shape_ff  <= curve_shape_in;
         last_reading_ff <= last_reading_in;
         zero_offset_ff  <= zero_offset_in;
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      v_ff      <= v_in;
      t_ff      <= t_in;
      opb_ff    <= opb_in;
      idx_ff    <= idx_in;
      x_ff      <= x_in;
      lg_ff     <= lg_in;
      cnt_ff    <= cnt_in;
      sh_ff     <= sh_in;
      base_ff   <= base_in;
      cc_ff     <= cc_in;
      rsp_cc_ff <= rsp_cc_in;
   end

   assign req_bus.ready    = (state_ff == S_IDLE);
   assign csr_bus.ready    = 1'b1;
   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.cc_value = rsp_cc_ff;

   // A new result appears only from the completion state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result raised outside completion state");

   // The log scaling starts only after the last squaring step
   a_log_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOGLN) |-> ($past(state_ff) == S_LOGSQ && $past(cnt_ff) == '0))
      else $error("log generator left squaring early");

   // Zero offset stays inside one g
   a_offset_range: assert property (@(posedge clock) disable iff (reset)
      (zero_offset_ff <= OFS_MAX) && (zero_offset_ff >= OFS_MIN))
      else $error("zero offset out of range");

   // Divider finishes only while the sequencer waits for it
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished while not awaited");

endmodule

@@ dv/tb_motion_sensor_curve_to_cc_core.sv @@
// Self-checking testbench for the motion sensor curve mapper, with a predictor and random handshakes.
`timescale 1ns / 1ps

module tb_motion_sensor_curve_to_cc_core;

   localparam int SAMPLE_BITS   = mscc_pkg::SAMPLE_BITS_DEF;
   localparam int FRACTION_BITS = mscc_pkg::FRACTION_BITS_DEF;
   localparam int CC_BITS       = mscc_pkg::CC_BITS;
   localparam int OP_BITS       = mscc_pkg::OP_BITS;
   localparam longint unsigned LOG_N = 64'(mscc_pkg::LOG_ENTRIES_DEF);
   localparam longint FULL_SCALE = longint'(1) << (SAMPLE_BITS - 1);
   localparam longint ONE_G      = longint'(1) << (SAMPLE_BITS - 3);
   localparam longint unsigned E_MINUS_ONE_Q32 =
      (64'd1 << 32) | 64'(mscc_pkg::E_MINUS_ONE_FRAC);
   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES  = 80;
   localparam int IDLE_LIMIT    = 2000;
   localparam int ITEMS_PER_SET = 112;

   typedef struct packed {
      logic [OP_BITS-1:0]            operation;
      logic signed [SAMPLE_BITS-1:0] sample;
   } req_item_type;

   logic clock;
   logic reset;

   mscc_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_if ();
   mscc_rsp_if                              rsp_if ();
   mscc_csr_if                              csr_if ();

   motion_sensor_curve_to_cc_core #(
      .SAMPLE_BITS      (SAMPLE_BITS),
      .LOG_TABLE_ENTRIES(mscc_pkg::LOG_ENTRIES_DEF),
      .FRACTION_BITS    (FRACTION_BITS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_if),
      .rsp_bus(rsp_if),
      .csr_bus(csr_if)
   );

   // Predictor state and configuration
   logic                 cfg_accel;
   logic [2:0]           cfg_curve;
   longint               last_reading_q;
   longint               zero_offset_q;
   logic [CC_BITS-1:0]   cc_expected[$];

   req_item_type         pending_reqs[$];
   int                   reqs_pushed;
   int                   reqs_accepted;
   int                   mismatch_count;
   int                   idle_cycles;

   // Sender burst and gap bookkeeping
   int                   burst_left;
   int                   gap_left;
   req_item_type         req_next;

   // Receiver stall pattern
   int                   stall_mode;
   int                   stall_mode_left;
   int                   stall_tick;
   logic                 ready_next;
   logic [CC_BITS-1:0]   cc_want;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Log table word: Q30 log2 by repeated squaring, scaled by ln2, rounded half up
   function automatic longint unsigned log_word(longint unsigned idx);
      longint unsigned x, lg, p;
      lg = 0;
      if (idx >= LOG_N) idx = LOG_N - 1;
      x = (64'd1 << 30) + ((E_MINUS_ONE_Q32 * idx / LOG_N) >> 2);
      if (x >= (64'd2 << 30)) begin
         lg = 64'd1 << 30;
         x  = x >> 1;
      end
      for (int b = 29; b >= 0; b--) begin
         x = (x * x) >> 30;
         if (x >= (64'd2 << 30)) begin
            x  = x >> 1;
            lg = lg | (64'd1 << b);
         end
      end
      p = lg * 64'(mscc_pkg::LN_TWO_Q32);
      return (p + (64'd1 << (61 - FRACTION_BITS))) >> (62 - FRACTION_BITS);
   endfunction

   // Re-center an accelerometer sample on the zero offset, saturating to the sample range
   function automatic longint recenter_sample(longint s);
      longint o, r;
      o = zero_offset_q;
      if (s >= o) begin
         r = (s - o) * ONE_G / (ONE_G - o);
         if (r > FULL_SCALE - 1) r = FULL_SCALE - 1;
      end else begin
         r = (o - s) * ONE_G / (ONE_G + o);
         if (r > FULL_SCALE) r = FULL_SCALE;
         r = -r;
      end
      return r;
   endfunction

   // Map a signed value through the selected curve, floor then clamp
   function automatic logic [CC_BITS-1:0] shape_curve(longint v);
      longint unsigned w, h;
      longint cc;
      w = longint'(v + FULL_SCALE);
      h = longint'(v);
      case (cfg_curve)
         mscc_pkg::CURVE_LOG: begin
            cc = longint'((log_word((w * LOG_N) >> SAMPLE_BITS)
                 * 64'(mscc_pkg::SCALE_FULL)) >> FRACTION_BITS);
         end
         mscc_pkg::CURVE_SQUARE: begin
            cc = longint'((w * w * 64'(mscc_pkg::SCALE_FULL)) >> (2 * SAMPLE_BITS));
         end
         mscc_pkg::CURVE_LOG_SQUARE: begin
            if (v < 0) begin
               cc = longint'((log_word((w * LOG_N) >> (SAMPLE_BITS - 1))
                    * 64'(mscc_pkg::SCALE_HALF_LO)) >> FRACTION_BITS);
            end else begin
               cc = 64 + longint'((h * h * 64'(mscc_pkg::SCALE_HALF_HI))
                    >> (2 * (SAMPLE_BITS - 1)));
            end
         end
         mscc_pkg::CURVE_SQUARE_LOG: begin
            if (v < 0) begin
               cc = longint'((w * w * 64'(mscc_pkg::SCALE_HALF_LO))
                    >> (2 * (SAMPLE_BITS - 1)));
            end else begin
               cc = 64 + longint'((log_word((h * LOG_N) >> (SAMPLE_BITS - 1))
                    * 64'(mscc_pkg::SCALE_HALF_HI)) >> FRACTION_BITS);
            end
         end
         default: begin
            cc = longint'((w * 64'(mscc_pkg::SCALE_FULL)) >> SAMPLE_BITS);
         end
      endcase
      if (cc < 0) cc = 0;
      if (cc > 127) cc = 127;
      return cc[CC_BITS-1:0];
   endfunction

   // Advance the predictor by one accepted request
   function automatic void apply_request(logic [OP_BITS-1:0] op,
                                         logic signed [SAMPLE_BITS-1:0] smp);
      longint s;
      case (op)
         mscc_pkg::OP_SAMPLE: begin
            s = longint'(smp);
            last_reading_q = s;
            cc_expected.push_back(shape_curve(cfg_accel ? recenter_sample(s) : s));
         end
         mscc_pkg::OP_CAPTURE: begin
            if (cfg_accel) begin
               s = last_reading_q;
               if (s > ONE_G - 1) s = ONE_G - 1;
               if (s < -(ONE_G - 1)) s = -(ONE_G - 1);
               zero_offset_q = s;
            end
         end
         mscc_pkg::OP_CLEAR: begin
            zero_offset_q = 0;
         end
         default: ;
      endcase
   endfunction

   // Random sample weighted toward the extremes, zero and the 1 g points
   function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
      case ($urandom_range(0, 9))
         0: return {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
         1: return {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
         2: return SAMPLE_BITS'(int'($urandom_range(0, 128)) - 64);
         3: return SAMPLE_BITS'(int'($urandom_range(0, 2 * 9000)) - 9000);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   function automatic void push_req(logic [OP_BITS-1:0] op, logic signed [SAMPLE_BITS-1:0] smp);
      req_item_type it;
      it.operation = op;
      it.sample    = smp;
      pending_reqs.push_back(it);
      reqs_pushed++;
   endfunction

   // Write one register through the CSR channel and mirror it in the predictor
   task automatic write_reg(logic [mscc_pkg::CSR_INDEX_BITS-1:0] idx, logic [2:0] value);
      logic [mscc_pkg::CSR_DATA_BITS-1:0] data;
      data = {(mscc_pkg::CSR_DATA_BITS - 3)'($urandom_range(0, 31)), value};
      if (idx == mscc_pkg::REG_ACCEL_MODE) data[2:1] = 2'($urandom_range(0, 3));
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      if (idx == mscc_pkg::REG_ACCEL_MODE) cfg_accel = data[0];
      else                                 cfg_curve = data[2:0];
      csr_if.valid <= 1'b0;
   endtask

   // Hold until every pushed request is accepted and every result is back, then drain
   task automatic wait_quiet();
      do @(posedge clock); while (reqs_accepted != reqs_pushed || cc_expected.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Request driver: bursts of transfers with random gaps
   always @(posedge clock) begin : req_driver
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            apply_request(req_if.operation, req_if.sample);
            reqs_accepted++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_next = pending_reqs.pop_front();
               req_if.valid     <= 1'b1;
               req_if.operation <= req_next.operation;
               req_if.sample    <= req_next.sample;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: check each transfer against the oldest expectation
   always @(posedge clock) begin : rsp_monitor
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (cc_expected.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected cc_value, expected none, actual %0d",
                        $time, rsp_if.cc_value);
            end else begin
               cc_want = cc_expected.pop_front();
               if (rsp_if.cc_value !== cc_want) begin
                  mismatch_count++;
                  $display("%0t: cc_value differs, expected %0d, actual %0d",
                           $time, cc_want, rsp_if.cc_value);
               end
            end
         end
         // Switch stall pattern now and then: none, light, heavy, periodic
         if (stall_mode_left <= 0) begin
            stall_mode      = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(64, 256);
         end
         stall_mode_left--;
         stall_tick++;
         case (stall_mode)
            0: ready_next = 1'b1;
            1: ready_next = ($urandom_range(0, 3) != 0);
            2: ready_next = ($urandom_range(0, 3) == 0);
            default: ready_next = (stall_tick % 7) < 3;
         endcase
         rsp_if.ready <= ready_next;
      end
   end

   // Count cycles without any transfer
   always @(posedge clock) begin : transfer_watch
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   // Stimulus and end of run
   initial begin : stimulus
      int cfg_order[16];
      int i, j, t, n_done;
      logic [OP_BITS-1:0] op;

      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.operation = mscc_pkg::OP_SAMPLE;
      req_if.sample   = '0;
      rsp_if.ready    = 1'b0;
      csr_if.valid    = 1'b0;
      csr_if.index    = mscc_pkg::REG_ACCEL_MODE;
      csr_if.data     = '0;
      cfg_accel       = 1'b0;
      cfg_curve       = mscc_pkg::CURVE_LINEAR;
      last_reading_q  = 0;
      zero_offset_q   = 0;
      reqs_pushed     = 0;
      reqs_accepted   = 0;
      mismatch_count  = 0;
      idle_cycles     = 0;
      burst_left      = 1;
      gap_left        = 0;
      stall_mode      = 0;
      stall_mode_left = 0;
      stall_tick      = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: accelerometer mode, split log/square curve
      write_reg(mscc_pkg::REG_ACCEL_MODE, 3'd1);
      write_reg(mscc_pkg::REG_CURVE_SHAPE, mscc_pkg::CURVE_LOG_SQUARE);
      push_req(mscc_pkg::OP_SAMPLE, 16'sd0);
      push_req(mscc_pkg::OP_SAMPLE, -16'sd32768);
      push_req(mscc_pkg::OP_SAMPLE, 16'sd32767);
      push_req(mscc_pkg::OP_SAMPLE, -16'sd1);
      push_req(mscc_pkg::OP_SAMPLE, 16'sd1);
      push_req(mscc_pkg::OP_CAPTURE, 16'sd0);
      push_req(mscc_pkg::OP_SAMPLE, 16'sd1);
      push_req(mscc_pkg::OP_SAMPLE, 16'sd0);
      // Offset from a full-scale reading clamps to just under 1 g; re-centred value saturates
      push_req(mscc_pkg::OP_SAMPLE, 16'sd32767);
      push_req(mscc_pkg::OP_CAPTURE, -16'sd1);
      push_req(mscc_pkg::OP_SAMPLE, 16'sd8190);
      push_req(mscc_pkg::OP_SAMPLE, 16'sd8191);
      push_req(mscc_pkg::OP_SAMPLE, 16'sd32767);
      push_req(mscc_pkg::OP_SAMPLE, -16'sd32768);
      push_req(mscc_pkg::OP_CAPTURE, 16'sd12345);
      push_req(mscc_pkg::OP_SAMPLE, -16'sd32768);
      push_req(mscc_pkg::OP_SAMPLE, 16'sd32767);
      // Unused operation code is dropped
      push_req(OP_UNUSED, 16'sd12345);
      push_req(mscc_pkg::OP_CLEAR, -16'sd1);
      push_req(mscc_pkg::OP_SAMPLE, -16'sd16384);
      push_req(mscc_pkg::OP_SAMPLE, 16'sd16384);
      wait_quiet();

      // Random: every mode and curve code, in shuffled order
      for (i = 0; i < 16; i++) cfg_order[i] = i;
      for (i = 15; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = cfg_order[i];
         cfg_order[i] = cfg_order[j];
         cfg_order[j] = t;
      end
      for (i = 0; i < 16; i++) begin
         write_reg(mscc_pkg::REG_ACCEL_MODE, 3'(cfg_order[i] / 8));
         write_reg(mscc_pkg::REG_CURVE_SHAPE, 3'(cfg_order[i] % 8));
         n_done = 0;
         while (n_done < ITEMS_PER_SET) begin
            t = $urandom_range(0, 99);
            if (t < 70)      op = mscc_pkg::OP_SAMPLE;
            else if (t < 82) op = mscc_pkg::OP_CAPTURE;
            else if (t < 93) op = mscc_pkg::OP_CLEAR;
            else             op = OP_UNUSED;
            push_req(op, rand_sample());
            n_done++;
         end
         wait_quiet();
      end

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/mscc_pkg.sv
rtl/mscc_if.sv
rtl/mscc_recentre.sv
rtl/motion_sensor_curve_to_cc_core.sv
dv/tb_motion_sensor_curve_to_cc_core.sv
